// ===== sv/hcts_pkg.sv =====
// Shared types and constants for the HTML comment text scanner.
`timescale 1ns / 1ps

package hcts_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] CpDash = 21'h00002D;
  localparam logic [CpWidth-1:0] CpGt   = 21'h00003E;
  localparam logic [CpWidth-1:0] CpLt   = 21'h00003C;
  localparam logic [CpWidth-1:0] CpBang = 21'h000021;
  localparam logic [CpWidth-1:0] CpNul  = 21'h000000;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DASH,
    CLS_GT,
    CLS_LT,
    CLS_BANG,
    CLS_NUL
  } char_class_t;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_ACCEPT  = 2'd1,
    VERDICT_REJECT  = 2'd2
  } verdict_t;

  // Classified item passed from the front end to the scanner core.
  typedef struct packed {
    logic        start_scan;
    logic        at_end;
    char_class_t cls;
  } scan_item_t;

endpackage

// ===== sv/hcts_front.sv =====
// Front end: reduces a code point to the character class the scanner needs.
`timescale 1ns / 1ps

module hcts_front (
  input  logic                         start_scan,
  input  logic                         at_end,
  input  logic [hcts_pkg::CpWidth-1:0] code_point,
  output hcts_pkg::scan_item_t         item
);
  import hcts_pkg::*;

  char_class_t cls;

  always_comb begin
    if (code_point == CpDash) begin
      cls = CLS_DASH;
    end else if (code_point == CpGt) begin
      cls = CLS_GT;
    end else if (code_point == CpLt) begin
      cls = CLS_LT;
    end else if (code_point == CpBang) begin
      cls = CLS_BANG;
    end else if (code_point == CpNul) begin
      cls = CLS_NUL;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign item.start_scan = start_scan;
  assign item.at_end     = at_end;
  assign item.cls        = cls;

endmodule

// ===== sv/hcts_queue.sv =====
// Two-entry queue between the front end and the scanner core.
`timescale 1ns / 1ps

module hcts_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  hcts_pkg::scan_item_t wr_item,
  output logic                 full,
  input  logic                 rd_en,
  output hcts_pkg::scan_item_t rd_item,
  output logic                 not_empty
);
  import hcts_pkg::*;

  scan_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/hcts_back.sv =====
// Scanner core: comment tokenizer states and the registered result.
`timescale 1ns / 1ps

module hcts_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  hcts_pkg::scan_item_t item,
  output logic                 item_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 extend_token,
  output logic [1:0]           verdict
);
  import hcts_pkg::*;

  typedef enum logic [3:0] {
    ST_START,
    ST_START_DASH,
    ST_TEXT,
    ST_LT,
    ST_LT_BANG,
    ST_LT_BANG_DASH,
    ST_LT_BANG_DASH_DASH,
    ST_END_DASH,
    ST_END,
    ST_END_BANG
  } scan_state_t;

  scan_state_t scan_state;
  logic        seen_text;
  logic        scan_active;

  scan_state_t scan_state_next;
  logic        seen_text_next;
  logic        scan_active_next;
  logic        mark;
  verdict_t    res;
  verdict_t    res_next;
  logic        mark_next;

  scan_state_t cur;
  logic        seen_cur;
  logic        active_cur;

  // Comment text state on the current character (also reused after reconsume).
  scan_state_t txt_state;
  logic        txt_mark;
  verdict_t    txt_res;

  assign item_pop = item_valid && (!out_valid || !out_stall);

  always_comb begin
    cur        = item.start_scan ? ST_START : scan_state;
    seen_cur   = item.start_scan ? 1'b0 : seen_text;
    active_cur = item.start_scan | scan_active;

    txt_state = ST_TEXT;
    txt_mark  = 1'b1;
    txt_res   = VERDICT_PENDING;
    case (item.cls)
      CLS_LT:   txt_state = ST_LT;
      CLS_DASH: begin
        txt_state = ST_END_DASH;
        txt_mark  = 1'b0;
      end
      CLS_NUL:  begin
        txt_mark = 1'b0;
        txt_res  = VERDICT_REJECT;
      end
      default:  txt_state = ST_TEXT;
    endcase

    scan_state_next = cur;
    mark            = 1'b0;
    res             = VERDICT_PENDING;
    case (cur)
      ST_START: begin
        if (item.cls == CLS_DASH) begin
          scan_state_next = ST_START_DASH;
        end else if (item.cls == CLS_GT) begin
          res = VERDICT_REJECT;
        end else begin
          scan_state_next = txt_state;
          mark            = txt_mark;
          res             = txt_res;
        end
      end
      ST_START_DASH: begin
        if (item.cls == CLS_DASH) begin
          scan_state_next = ST_END;
        end else if (item.cls == CLS_GT) begin
          res = VERDICT_REJECT;
        end else begin
          scan_state_next = txt_state;
          mark            = 1'b1;
          res             = txt_res;
        end
      end
      ST_TEXT: begin
        scan_state_next = txt_state;
        mark            = txt_mark;
        res             = txt_res;
      end
      ST_LT: begin
        if (item.cls == CLS_BANG) begin
          scan_state_next = ST_LT_BANG;
          mark            = 1'b1;
        end else if (item.cls == CLS_LT) begin
          mark = 1'b1;
        end else begin
          scan_state_next = txt_state;
          mark            = txt_mark;
          res             = txt_res;
        end
      end
      ST_LT_BANG: begin
        if (item.cls == CLS_DASH) begin
          scan_state_next = ST_LT_BANG_DASH;
        end else begin
          scan_state_next = txt_state;
          mark            = txt_mark;
          res             = txt_res;
        end
      end
      ST_LT_BANG_DASH: begin
        // non-dash reconsumes via end dash, which marks and goes to text
        if (item.cls == CLS_DASH) begin
          scan_state_next = ST_LT_BANG_DASH_DASH;
        end else begin
          scan_state_next = txt_state;
          mark            = 1'b1;
          res             = txt_res;
        end
      end
      ST_LT_BANG_DASH_DASH: begin
        if (item.cls == CLS_GT) begin
          res = seen_cur ? VERDICT_ACCEPT : VERDICT_REJECT;
        end else begin
          res = VERDICT_REJECT;
        end
      end
      ST_END_DASH: begin
        if (item.cls == CLS_DASH) begin
          scan_state_next = ST_END;
        end else begin
          scan_state_next = txt_state;
          mark            = 1'b1;
          res             = txt_res;
        end
      end
      ST_END: begin
        if (item.cls == CLS_GT) begin
          res = seen_cur ? VERDICT_ACCEPT : VERDICT_REJECT;
        end else if (item.cls == CLS_BANG) begin
          scan_state_next = ST_END_BANG;
        end else if (item.cls == CLS_DASH) begin
          mark = 1'b1;
        end else begin
          scan_state_next = txt_state;
          mark            = 1'b1;
          res             = txt_res;
        end
      end
      ST_END_BANG: begin
        if (item.cls == CLS_DASH) begin
          scan_state_next = ST_END_DASH;
          mark            = 1'b1;
        end else if (item.cls == CLS_GT) begin
          res = VERDICT_REJECT;
        end else begin
          scan_state_next = txt_state;
          mark            = 1'b1;
          res             = txt_res;
        end
      end
      default: res = VERDICT_REJECT;
    endcase

    seen_text_next   = seen_cur | mark;
    scan_active_next = active_cur;
    res_next         = VERDICT_PENDING;
    mark_next        = 1'b0;
    if (active_cur) begin
      res_next  = item.at_end ? VERDICT_REJECT : res;
      mark_next = (res_next == VERDICT_PENDING) && mark;
      if (res_next != VERDICT_PENDING) begin
        scan_active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state  <= ST_START;
      seen_text   <= 1'b0;
      scan_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (item_pop) begin
        if (active_cur) begin
          scan_state <= scan_state_next;
          seen_text  <= seen_text_next;
        end
        scan_active <= scan_active_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      extend_token <= mark_next;
      verdict      <= res_next;
    end
  end

endmodule

// ===== sv/html_comment_text_scanner_top.sv =====
// Top level of the HTML comment text scanner.
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// input   | in_valid / in_stall  | start_scan, at_end, code_point
// output  | out_valid / out_stall| extend_token, verdict
//
// One code point per cycle while in_stall is low; a result is registered on the
// output when its item is popped from the head of the two-entry queue, after
// passing through the queue. in_stall rises only when the queue is full.
// rst (synchronous) empties the queue and sets the idle scan state.
// A stalled output holds its result while the queue takes items until full.

module html_comment_text_scanner_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         start_scan,
  input  logic                         at_end,
  input  logic [hcts_pkg::CpWidth-1:0] code_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         extend_token,
  output logic [1:0]                   verdict
);
  import hcts_pkg::*;

  scan_item_t front_item;
  scan_item_t head_item;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;

  assign in_stall = q_full;

  hcts_front u_front (
    .start_scan (start_scan),
    .at_end     (at_end),
    .code_point (code_point),
    .item       (front_item)
  );

  hcts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_valid && !q_full),
    .wr_item   (front_item),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_item   (head_item),
    .not_empty (q_not_empty)
  );

  hcts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (q_not_empty),
    .item         (head_item),
    .item_pop     (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .extend_token (extend_token),
    .verdict      (verdict)
  );

endmodule
